FILE: design/bfg_pkg.sv
// Package for the battery voltage fuel gauge: widths, the LiPo discharge table,
// configuration register indexes and the stream field layout.
// No dependencies.
package bfg_pkg;

  localparam int TABLE_POINTS = 21;
  localparam int SAMPLE_BITS  = 12;

  // Field widths
  localparam int RAW_FIELD_W = 12;
  localparam int RAW_W       = (SAMPLE_BITS < RAW_FIELD_W) ? SAMPLE_BITS : RAW_FIELD_W;
  localparam int CODE_W      = 12;
  localparam int TRIM_W      = 11;
  localparam int MV_W        = 14;
  localparam int CHARGE_W    = 10;

  localparam int MV_MAX     = 2 ** MV_W - 1;
  localparam int CHARGE_MAX = 1000;

  // 3300/1001 mV per code, gain in thousandths
  localparam int CODE_MV_NUM = 3300;
  localparam int CODE_MV_DEN = 1001;
  localparam int PERMILLE    = 1000;

  // Datapath widths
  localparam int GAIN_W = 11;                 // clamped gain, 0..2023
  localparam int G_W    = 23;                 // gain * 3300
  localparam int DEN_W  = 32;                 // cal * 1001 * 1000
  localparam int P1_W   = RAW_W + CODE_W;     // raw * measured ref
  localparam int NUM_W  = P1_W + G_W;         // full numerator
  localparam int RW     = DEN_W + MV_W;       // divider remainder
  localparam int OVW    = (NUM_W > RW) ? NUM_W : RW;

  // Interpolation
  localparam int CHARGE_STEP = CHARGE_MAX / (TABLE_POINTS - 1);
  localparam int FQ_W        = $clog2(CHARGE_STEP + 1);   // fraction quotient <= step
  localparam int FRW         = MV_W + FQ_W;
  localparam int CNT_W       = $clog2(TABLE_POINTS + 1);
  localparam int IDX_W       = $clog2(TABLE_POINTS);

  typedef logic [MV_W-1:0] mv_t;

  localparam mv_t LIPO_MV [TABLE_POINTS] = '{
    14'd3300, 14'd3500, 14'd3690, 14'd3710, 14'd3730, 14'd3750, 14'd3770,
    14'd3790, 14'd3800, 14'd3820, 14'd3840, 14'd3850, 14'd3870, 14'd3910,
    14'd3950, 14'd3980, 14'd4020, 14'd4080, 14'd4110, 14'd4150, 14'd4200
  };

  // Stream and config port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  // Result layout in out_tdata
  localparam int OUT_MV_LSB   = 0;
  localparam int OUT_CHG_LSB  = MV_W;
  localparam int OUT_CRIT_BIT = MV_W + CHARGE_W;
  localparam int OUT_PAD_W    = OUT_TDATA_W - MV_W - CHARGE_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VREF_CAL  = CFG_IDX_W'(0),
    CFG_VREF_MEAS = CFG_IDX_W'(1),
    CFG_TRIM      = CFG_IDX_W'(2),
    CFG_CRITICAL  = CFG_IDX_W'(3)
  } cfg_reg_t;

  // Side data carried through the interpolation divider
  typedef struct packed {
    logic [MV_W-1:0]     mv;
    logic                crit;
    logic                below;
    logic                above;
    logic                zspan;
    logic [CHARGE_W-1:0] base;
    logic [MV_W-1:0]     span;
  } frac_side_t;

endpackage

FILE: design/battery_voltage_fuel_gauge.sv
// Battery voltage fuel gauge top level: scaling pipeline, table lookup and
// interpolation pipeline. Depends on bfg_pkg.
//
// One 12-bit ADC sample in, one result out: battery millivolts (exact
// floor of raw*3300*vref_meas*(1000+trim)/(1001*vref_cal*1000), saturated
// at 16383), state of charge in tenths of a percent from a 21-point LiPo
// table with linear interpolation, and a critical flag (mv < critical_mv).
// The block takes one request per clock unless a result waits at the output.
// The pipeline holds three stages for the input register and the two
// multiplies, one overflow check plus one restoring-divider stage per
// millivolt bit (14), two stages for the table search, one for the step
// multiply and one divider stage per fraction bit (6), then the output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so in_tready drops only while a result waits.
// Config writes are always accepted (cfg_ready is tied high) and must only
// be issued while no request is in flight; a write to an unknown index is
// dropped. Derived scale factors settle in the cycle after a write.
module battery_voltage_fuel_gauge (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] raw_sample, rest zero
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfg_pkg::OUT_TDATA_W-1:0] out_tdata,  // [13:0] battery_mv,
                                                      // [23:14] charge_tenths,
                                                      // [24] critical, rest zero
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MV_W  = bfg_pkg::MV_W;
  localparam int FQ_W  = bfg_pkg::FQ_W;
  localparam int RW    = bfg_pkg::RW;
  localparam int FRW   = bfg_pkg::FRW;
  localparam int TP    = bfg_pkg::TABLE_POINTS;

  // ---------------------------------------------------------------------
  // Config registers and derived scale factors
  // ---------------------------------------------------------------------
  logic [bfg_pkg::CODE_W-1:0] vref_cal_r, vref_meas_r;
  logic [bfg_pkg::TRIM_W-1:0] trim_r;
  logic [MV_W-1:0]            crit_mv_r;
  logic [bfg_pkg::G_W-1:0]    gmul_r, gmul_nxt;
  logic [bfg_pkg::DEN_W-1:0]  den_r, den_nxt;

  logic signed [bfg_pkg::GAIN_W:0] gain_s;
  logic [bfg_pkg::GAIN_W-1:0]      gain_u;
  logic [bfg_pkg::CODE_W-1:0]      cal_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_cal_r  <= bfg_pkg::CODE_W'(1638);
      vref_meas_r <= bfg_pkg::CODE_W'(1638);
      trim_r      <= '0;
      crit_mv_r   <= MV_W'(3600);
    end else if (cfg_valid && cfg_ready) begin
      case (bfg_pkg::cfg_reg_t'(cfg_index))
        bfg_pkg::CFG_VREF_CAL:  vref_cal_r  <= cfg_data[bfg_pkg::CODE_W-1:0];
        bfg_pkg::CFG_VREF_MEAS: vref_meas_r <= cfg_data[bfg_pkg::CODE_W-1:0];
        bfg_pkg::CFG_TRIM:      trim_r      <= cfg_data[bfg_pkg::TRIM_W-1:0];
        bfg_pkg::CFG_CRITICAL:  crit_mv_r   <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // gain = 1000 + trim, negative gain forces zero volts; cal of 0 acts as 1
  always_comb begin
    gain_s   = (bfg_pkg::GAIN_W+1)'(signed'(trim_r))
             + (bfg_pkg::GAIN_W+1)'(bfg_pkg::PERMILLE);
    gain_u   = gain_s[bfg_pkg::GAIN_W] ? '0 : gain_s[bfg_pkg::GAIN_W-1:0];
    cal_eff  = (vref_cal_r == '0) ? bfg_pkg::CODE_W'(1) : vref_cal_r;
    gmul_nxt = bfg_pkg::G_W'(gain_u) * bfg_pkg::G_W'(bfg_pkg::CODE_MV_NUM);
    den_nxt  = bfg_pkg::DEN_W'(cal_eff)
             * bfg_pkg::DEN_W'(bfg_pkg::CODE_MV_DEN * bfg_pkg::PERMILLE);
  end

  always_ff @(posedge clk) begin
    gmul_r <= gmul_nxt;
    den_r  <= den_nxt;
  end

  // ---------------------------------------------------------------------
  // Pipeline advance: everything moves when the output slot frees up
  // ---------------------------------------------------------------------
  logic ce;
  logic out_v_r;

  assign ce        = !out_v_r || out_tready;
  assign in_tready = ce;

  // ---------------------------------------------------------------------
  // Stages 1-3: input register, raw*meas, *gain*3300
  // ---------------------------------------------------------------------
  logic                        s1_v_r, s2_v_r, s3_v_r;
  logic [bfg_pkg::RAW_W-1:0]   s1_raw_r;
  logic [bfg_pkg::P1_W-1:0]    s2_p1_r;
  logic [bfg_pkg::NUM_W-1:0]   s3_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (ce) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_raw_r <= in_tdata[bfg_pkg::RAW_W-1:0];
      s2_p1_r  <= bfg_pkg::P1_W'(s1_raw_r) * bfg_pkg::P1_W'(vref_meas_r);
      s3_num_r <= bfg_pkg::NUM_W'(s2_p1_r) * bfg_pkg::NUM_W'(gmul_r);
    end
  end

  // ---------------------------------------------------------------------
  // Voltage divider: overflow check, then one quotient bit per stage
  // ---------------------------------------------------------------------
  logic            d_v_r   [MV_W+1];
  logic [RW-1:0]   d_rem_r [MV_W+1];
  logic [MV_W-1:0] d_q_r   [MV_W+1];
  logic            d_ovf_r [MV_W+1];
  logic            d_v_nxt   [MV_W+1];
  logic [RW-1:0]   d_rem_nxt [MV_W+1];
  logic [MV_W-1:0] d_q_nxt   [MV_W+1];
  logic            d_ovf_nxt [MV_W+1];

  logic ovf0;

  // quotient would reach 2^MV_W: saturate
  assign ovf0 = bfg_pkg::OVW'(s3_num_r) >= bfg_pkg::OVW'({den_r, {MV_W{1'b0}}});

  always_comb begin
    d_v_nxt[0]   = s3_v_r;
    d_ovf_nxt[0] = ovf0;
    d_rem_nxt[0] = ovf0 ? '0 : RW'(s3_num_r);
    d_q_nxt[0]   = '0;
  end

  for (genvar i = 0; i < MV_W; i++) begin : g_div
    localparam int B = MV_W - 1 - i;
    logic [RW:0] trial;
    logic        take;
    always_comb begin
      trial          = {1'b0, d_rem_r[i]} - {1'b0, RW'(den_r) << B};
      take           = !trial[RW];
      d_v_nxt[i+1]   = d_v_r[i];
      d_ovf_nxt[i+1] = d_ovf_r[i];
      d_rem_nxt[i+1] = take ? trial[RW-1:0] : d_rem_r[i];
      d_q_nxt[i+1]   = {d_q_r[i][MV_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MV_W; i++) d_v_r[i] <= 1'b0;
    end else if (ce) begin
      for (int i = 0; i <= MV_W; i++) d_v_r[i] <= d_v_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i <= MV_W; i++) begin
        d_rem_r[i] <= d_rem_nxt[i];
        d_q_r[i]   <= d_q_nxt[i];
        d_ovf_r[i] <= d_ovf_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Table search, stage A: compare against every table point
  // ---------------------------------------------------------------------
  logic [MV_W-1:0] mv_fin;
  logic            ca_v_r, ca_crit_r, ca_above_r;
  logic [MV_W-1:0] ca_mv_r;
  logic [TP-1:0]   ca_gt_r, ca_gt_nxt;

  assign mv_fin = d_ovf_r[MV_W] ? MV_W'(bfg_pkg::MV_MAX) : d_q_r[MV_W];

  always_comb begin
    for (int k = 0; k < TP; k++) ca_gt_nxt[k] = mv_fin > bfg_pkg::LIPO_MV[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ca_v_r <= 1'b0;
    else if (ce) ca_v_r <= d_v_r[MV_W];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ca_mv_r    <= mv_fin;
      ca_gt_r    <= ca_gt_nxt;
      ca_crit_r  <= mv_fin < crit_mv_r;
      ca_above_r <= mv_fin >= bfg_pkg::LIPO_MV[TP-1];
    end
  end

  // ---------------------------------------------------------------------
  // Table search, stage B: segment index, offset, span and base charge
  // ---------------------------------------------------------------------
  logic [bfg_pkg::CNT_W-1:0] cnt;
  logic [bfg_pkg::IDX_W-1:0] seg, seg_m1;
  logic                      below;
  logic [MV_W-1:0]           lo, hi;
  logic                      cb_v_r;
  logic [MV_W-1:0]           cb_diff_r;
  bfg_pkg::frac_side_t       cb_side_r, cb_side_nxt;

  // thermometer code: count of points strictly below mv
  always_comb begin
    cnt = '0;
    for (int k = 0; k < TP; k++) cnt = cnt + bfg_pkg::CNT_W'(ca_gt_r[k]);
  end

  always_comb begin
    below  = !ca_gt_r[0];
    seg    = (below || ca_above_r) ? bfg_pkg::IDX_W'(1) : cnt[bfg_pkg::IDX_W-1:0];
    seg_m1 = seg - bfg_pkg::IDX_W'(1);
    lo     = bfg_pkg::LIPO_MV[seg_m1];
    hi     = bfg_pkg::LIPO_MV[seg];
    cb_side_nxt.mv    = ca_mv_r;
    cb_side_nxt.crit  = ca_crit_r;
    cb_side_nxt.below = below;
    cb_side_nxt.above = ca_above_r;
    cb_side_nxt.zspan = hi <= lo;
    cb_side_nxt.base  = bfg_pkg::CHARGE_W'(seg_m1)
                      * bfg_pkg::CHARGE_W'(bfg_pkg::CHARGE_STEP);
    cb_side_nxt.span  = hi - lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cb_v_r <= 1'b0;
    else if (ce) cb_v_r <= ca_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cb_side_r <= cb_side_nxt;
      cb_diff_r <= ca_mv_r - lo;
    end
  end

  // ---------------------------------------------------------------------
  // Interpolation: step*(mv-lo), then one fraction bit per stage
  // ---------------------------------------------------------------------
  logic                f_v_r    [FQ_W+1];
  logic [FRW-1:0]      f_rem_r  [FQ_W+1];
  logic [FQ_W-1:0]     f_q_r    [FQ_W+1];
  bfg_pkg::frac_side_t f_side_r [FQ_W+1];
  logic                f_v_nxt    [FQ_W+1];
  logic [FRW-1:0]      f_rem_nxt  [FQ_W+1];
  logic [FQ_W-1:0]     f_q_nxt    [FQ_W+1];
  bfg_pkg::frac_side_t f_side_nxt [FQ_W+1];

  always_comb begin
    f_v_nxt[0]    = cb_v_r;
    f_rem_nxt[0]  = FRW'(cb_diff_r) * FRW'(bfg_pkg::CHARGE_STEP);
    f_q_nxt[0]    = '0;
    f_side_nxt[0] = cb_side_r;
  end

  for (genvar j = 0; j < FQ_W; j++) begin : g_frac
    localparam int B = FQ_W - 1 - j;
    logic [FRW:0] trial;
    logic         take;
    always_comb begin
      trial           = {1'b0, f_rem_r[j]} - {1'b0, FRW'(f_side_r[j].span) << B};
      take            = !trial[FRW];
      f_v_nxt[j+1]    = f_v_r[j];
      f_rem_nxt[j+1]  = take ? trial[FRW-1:0] : f_rem_r[j];
      f_q_nxt[j+1]    = {f_q_r[j][FQ_W-2:0], take};
      f_side_nxt[j+1] = f_side_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= FQ_W; j++) f_v_r[j] <= 1'b0;
    end else if (ce) begin
      for (int j = 0; j <= FQ_W; j++) f_v_r[j] <= f_v_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j <= FQ_W; j++) begin
        f_rem_r[j]  <= f_rem_nxt[j];
        f_q_r[j]    <= f_q_nxt[j];
        f_side_r[j] <= f_side_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: end-of-table cases and clamp
  // ---------------------------------------------------------------------
  bfg_pkg::frac_side_t           fs;
  logic [bfg_pkg::CHARGE_W:0]    sum;
  logic [bfg_pkg::CHARGE_W-1:0]  charge_nxt;
  logic [bfg_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_comb begin
    fs  = f_side_r[FQ_W];
    sum = (bfg_pkg::CHARGE_W+1)'(fs.base)
        + (fs.zspan ? '0 : (bfg_pkg::CHARGE_W+1)'(f_q_r[FQ_W]));
    if (fs.below) begin
      charge_nxt = '0;
    end else if (fs.above || sum > (bfg_pkg::CHARGE_W+1)'(bfg_pkg::CHARGE_MAX)) begin
      charge_nxt = bfg_pkg::CHARGE_W'(bfg_pkg::CHARGE_MAX);
    end else begin
      charge_nxt = sum[bfg_pkg::CHARGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (ce) out_v_r <= f_v_r[FQ_W];
  end

  always_ff @(posedge clk) begin
    if (ce) out_data_r <= {{bfg_pkg::OUT_PAD_W{1'b0}}, fs.crit, charge_nxt, fs.mv};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/bfg_checker.sv
// Port-level checker for the battery voltage fuel gauge, bound to the top level.
// Depends on bfg_pkg and battery_voltage_fuel_gauge.
module bfg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [bfg_pkg::MV_W-1:0]     mv;
  logic [bfg_pkg::CHARGE_W-1:0] chg;

  assign mv  = out_tdata[bfg_pkg::OUT_MV_LSB +: bfg_pkg::MV_W];
  assign chg = out_tdata[bfg_pkg::OUT_CHG_LSB +: bfg_pkg::CHARGE_W];

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only stalls while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output slot");

  a_chg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chg <= bfg_pkg::CHARGE_W'(bfg_pkg::CHARGE_MAX))
    else $error("charge above full");

  a_chg_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mv <= bfg_pkg::LIPO_MV[0] |-> chg == '0)
    else $error("charge not empty at bottom of table");

  a_chg_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mv >= bfg_pkg::LIPO_MV[bfg_pkg::TABLE_POINTS-1]
      |-> chg == bfg_pkg::CHARGE_W'(bfg_pkg::CHARGE_MAX))
    else $error("charge not full at top of table");

endmodule

bind battery_voltage_fuel_gauge bfg_checker u_bfg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
